@@ design/cbr_pkg.sv @@
// Shared widths, payload types and saturation helper for the box collision response core.
`default_nettype none

package cbr_pkg;

    // Field widths of one beat.
    localparam int COORD_WIDTH = 16;
    localparam int HALF_WIDTH  = 14;
    localparam int DAMP_WIDTH  = 9;
    localparam int DAMP_FRAC   = 8;
    localparam int DAMP_HALF   = 1 << (DAMP_FRAC - 1);
    localparam logic [DAMP_WIDTH-1:0] DAMP_RESET = DAMP_WIDTH'(205);

    // Derived internal widths.
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int SH_W   = HALF_WIDTH + 1;
    localparam int SUM_W  = ((DIFF_W > SH_W + 1) ? DIFF_W : SH_W + 1) + 1;
    localparam int PEN_W  = SUM_W - 1;
    localparam int REL_W  = COORD_WIDTH + 1;
    localparam int PROD_W = PEN_W + REL_W;
    localparam int MUL_W  = COORD_WIDTH + DAMP_WIDTH + 1;
    localparam int RND_W  = MUL_W + 1;
    localparam int POS_W  = ((COORD_WIDTH > PEN_W + 1) ? COORD_WIDTH : PEN_W + 1) + 1;
    localparam int SAT_W  = (RND_W > POS_W) ? RND_W : POS_W;

    // Velocity lanes of the damping unit.
    localparam int NUM_VEL = 4;
    localparam int VEL_AX  = 0;
    localparam int VEL_AY  = 1;
    localparam int VEL_BX  = 2;
    localparam int VEL_BY  = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [HALF_WIDTH-1:0]  half_t;
    typedef logic        [DAMP_WIDTH-1:0]  damp_t;

    // One input beat: a pair of boxes.
    typedef struct packed {
        coord_t a_pos_x;
        coord_t a_pos_y;
        coord_t a_vel_x;
        coord_t a_vel_y;
        half_t  a_half_size;
        coord_t b_pos_x;
        coord_t b_pos_y;
        coord_t b_vel_x;
        coord_t b_vel_y;
        half_t  b_half_size;
    } cbr_in_t;

    // One result beat.
    typedef struct packed {
        logic   hit;
        logic   vertical;
        coord_t new_a_pos_x;
        coord_t new_a_pos_y;
        coord_t new_a_vel_x;
        coord_t new_a_vel_y;
        coord_t new_b_vel_x;
        coord_t new_b_vel_y;
    } cbr_out_t;

    // Overlap and penetration results handed from the front end to the resolver.
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               rx_pos;
        logic               ry_pos;
        logic [PEN_W-1:0]   px;
        logic [PEN_W-1:0]   py;
        logic [REL_W-1:0]   abs_rx;
        logic [REL_W-1:0]   abs_ry;
        coord_t             a_pos_x;
        coord_t             a_pos_y;
        coord_t             a_vel_x;
        coord_t             a_vel_y;
        coord_t             b_vel_x;
        coord_t             b_vel_y;
    } cbr_geom_t;

    // Clamp a wide signed value to the coordinate range.
    function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = {{(SAT_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
        lo = {{(SAT_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};
        if (v > hi)
        begin
            return hi[COORD_WIDTH-1:0];
        end
        else if (v < lo)
        begin
            return lo[COORD_WIDTH-1:0];
        end
        return v[COORD_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

@@ design/box_collision_response_core.sv @@
// Top level of the box collision response core: four-stage pipeline and damping register.
//
//   Channel   Signals                         Beat taken when
//   --------  ------------------------------  ---------------------------
//   input     start, busy, item               start && !busy
//   result    done, result                    done (one cycle, no stall)
//   config    cfg_valid, cfg_ready, cfg_data  cfg_valid && cfg_ready
//
// One box pair enters every cycle; busy is never raised, so the input rate is one beat per clock.
// Each result passes through the four register stages
// (differences, overlap and penetration, cross products, axis selection).
// Reset clears the stage valid bits and loads the damping factor with its default of 205.
// The result side has no stall; cfg_ready is high only while no beat is in flight or offered.
`default_nettype none

module box_collision_response_core
    import cbr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire cbr_in_t   item,
    output logic           done,
    output cbr_out_t       result,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire damp_t     cfg_data
);

    damp_t                damping_reg;
    logic                 accept;
    logic                 front_busy, back_busy;
    cbr_geom_t            geom;
    coord_t [NUM_VEL-1:0] vel_in;
    coord_t [NUM_VEL-1:0] vel_damped;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign cfg_ready = !front_busy && !back_busy && !start;

    // Damping factor register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg <= DAMP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            damping_reg <= cfg_data;
        end
    end

    // Velocity lanes for the damping unit.
    always_comb
    begin
        vel_in[VEL_AX] = item.a_vel_x;
        vel_in[VEL_AY] = item.a_vel_y;
        vel_in[VEL_BX] = item.b_vel_x;
        vel_in[VEL_BY] = item.b_vel_y;
    end

    cbr_overlap u_overlap (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_item  (item),
        .busy     (front_busy),
        .geom     (geom)
    );

    cbr_damp u_damp (
        .clk     (clk),
        .damping (damping_reg),
        .vel     (vel_in),
        .damped  (vel_damped)
    );

    cbr_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .damped    (vel_damped),
        .busy      (back_busy),
        .out_valid (done),
        .out_item  (result)
    );

    // Every accepted beat produces its result.
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("accepted beat produced no result");

    // A result needs an earlier accepted beat.
    a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 4))
        else $error("result without an input beat");

    // A vertical resolution only follows a hit.
    a_vert_hit : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.vertical) |-> result.hit)
        else $error("vertical flagged without a hit");

    // Without a hit, box A position passes through.
    a_miss_pass : assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |->
            (result.new_a_pos_x == $past(item.a_pos_x, 4)) &&
            (result.new_a_pos_y == $past(item.a_pos_y, 4)))
        else $error("position changed on a miss");

endmodule

`default_nettype wire

@@ design/cbr_overlap.sv @@
// Front end: edge differences, overlap test and penetration depths over two stages.
`default_nettype none

module cbr_overlap
    import cbr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire cbr_in_t   in_item,
    output logic           busy,
    output cbr_geom_t      geom
);

    // Stage one registers.
    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [SH_W-1:0]          sh_reg;
    logic signed [REL_W-1:0]  rx_reg, ry_reg;
    coord_t                   apx_reg, apy_reg, avx_reg, avy_reg, bvx_reg, bvy_reg;

    logic signed [DIFF_W-1:0] dx_next, dy_next;
    logic [SH_W-1:0]          sh_next;
    logic signed [REL_W-1:0]  rx_next, ry_next;

    // Stage two register.
    cbr_geom_t geom_reg, geom_next;

    // Center offsets, summed half sizes and relative velocity.
    always_comb
    begin
        dx_next = DIFF_W'(in_item.a_pos_x) - DIFF_W'(in_item.b_pos_x);
        dy_next = DIFF_W'(in_item.a_pos_y) - DIFF_W'(in_item.b_pos_y);
        sh_next = SH_W'(in_item.a_half_size) + SH_W'(in_item.b_half_size);
        rx_next = REL_W'(in_item.a_vel_x) - REL_W'(in_item.b_vel_x);
        ry_next = REL_W'(in_item.a_vel_y) - REL_W'(in_item.b_vel_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sh_reg  <= sh_next;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        apx_reg <= in_item.a_pos_x;
        apy_reg <= in_item.a_pos_y;
        avx_reg <= in_item.a_vel_x;
        avy_reg <= in_item.a_vel_y;
        bvx_reg <= in_item.b_vel_x;
        bvy_reg <= in_item.b_vel_y;
    end

    // Overlap test and side choice from the sign of the relative velocity.
    logic signed [SUM_W-1:0] sh_wide;
    logic signed [SUM_W-1:0] ax_sum, bx_sum, ay_sum, by_sum;
    logic                    ov_x, ov_y;

    always_comb
    begin
        sh_wide = SUM_W'(signed'({1'b0, sh_reg}));
        ax_sum  = sh_wide + SUM_W'(dx_reg);
        bx_sum  = sh_wide - SUM_W'(dx_reg);
        ay_sum  = sh_wide + SUM_W'(dy_reg);
        by_sum  = sh_wide - SUM_W'(dy_reg);
        ov_x    = !ax_sum[SUM_W-1] && (ax_sum != '0) && !bx_sum[SUM_W-1] && (bx_sum != '0);
        ov_y    = !ay_sum[SUM_W-1] && (ay_sum != '0) && !by_sum[SUM_W-1] && (by_sum != '0);

        geom_next.valid   = s1_valid_reg;
        geom_next.hit     = ov_x && ov_y;
        geom_next.rx_pos  = !rx_reg[REL_W-1] && (rx_reg != '0);
        geom_next.ry_pos  = !ry_reg[REL_W-1] && (ry_reg != '0);
        geom_next.px      = geom_next.rx_pos ? ax_sum[PEN_W-1:0] : bx_sum[PEN_W-1:0];
        geom_next.py      = geom_next.ry_pos ? ay_sum[PEN_W-1:0] : by_sum[PEN_W-1:0];
        geom_next.abs_rx  = rx_reg[REL_W-1] ? REL_W'(-rx_reg) : REL_W'(rx_reg);
        geom_next.abs_ry  = ry_reg[REL_W-1] ? REL_W'(-ry_reg) : REL_W'(ry_reg);
        geom_next.a_pos_x = apx_reg;
        geom_next.a_pos_y = apy_reg;
        geom_next.a_vel_x = avx_reg;
        geom_next.a_vel_y = avy_reg;
        geom_next.b_vel_x = bvx_reg;
        geom_next.b_vel_y = bvy_reg;
    end

    // Stage two register; reset clears the whole beat, valid bit included.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg <= '0;
        end
        else
        begin
            geom_reg <= geom_next;
        end
    end

    assign geom = geom_reg;
    assign busy = s1_valid_reg || geom_reg.valid;

endmodule

`default_nettype wire

@@ design/cbr_damp.sv @@
// Damping unit: scales four velocities by the damping factor in two stages.
`default_nettype none

module cbr_damp
    import cbr_pkg::*;
(
    input  wire logic                   clk,
    input  wire damp_t                  damping,
    input  wire coord_t [NUM_VEL-1:0]   vel,
    output coord_t      [NUM_VEL-1:0]   damped
);

    for (genvar i = 0; i < NUM_VEL; i++)
    begin : g_lane
        logic signed [MUL_W-1:0] prod_next;
        logic signed [MUL_W-1:0] prod_reg;
        logic signed [RND_W-1:0] rounded;
        logic signed [RND_W-1:0] shifted;
        coord_t                  damped_reg;

        // Multiply by the unsigned Q1.8 factor.
        assign prod_next = MUL_W'(signed'(vel[i])) * MUL_W'(signed'({1'b0, damping}));

        // Round to nearest with ties upward, then saturate.
        always_comb
        begin
            rounded = RND_W'(prod_reg) + RND_W'(DAMP_HALF);
            shifted = rounded >>> DAMP_FRAC;
        end

        always_ff @(posedge clk)
        begin
            prod_reg   <= prod_next;
            damped_reg <= sat_coord(SAT_W'(shifted));
        end

        assign damped[i] = damped_reg;
    end

endmodule

`default_nettype wire

@@ design/cbr_resolve.sv @@
// Resolver: cross products, pushed-out positions and final selection over two stages.
`default_nettype none

module cbr_resolve
    import cbr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cbr_geom_t              geom,
    input  wire coord_t [NUM_VEL-1:0]   damped,
    output logic                        busy,
    output logic                        out_valid,
    output cbr_out_t                    out_item
);

    // Stage three registers.
    logic                 s3_valid_reg;
    logic                 s3_hit_reg;
    logic [PROD_W-1:0]    prod_v_reg, prod_h_reg;
    coord_t               pos_x_reg, pos_y_reg;
    coord_t               apx_reg, apy_reg, avx_reg, avy_reg, bvx_reg, bvy_reg;
    coord_t               dvel_reg [NUM_VEL];

    // Stage four registers.
    logic                 valid_reg;
    cbr_out_t             out_reg, out_next;

    // Cross products and candidate positions.
    logic [PROD_W-1:0]       prod_v_next, prod_h_next;
    logic signed [POS_W-1:0] px_wide, py_wide, x_moved, y_moved;

    always_comb
    begin
        prod_v_next = PROD_W'(geom.abs_ry) * PROD_W'(geom.px);
        prod_h_next = PROD_W'(geom.abs_rx) * PROD_W'(geom.py);
        px_wide     = POS_W'(signed'({1'b0, geom.px}));
        py_wide     = POS_W'(signed'({1'b0, geom.py}));
        x_moved     = geom.rx_pos ? POS_W'(geom.a_pos_x) - px_wide
                                  : POS_W'(geom.a_pos_x) + px_wide;
        y_moved     = geom.ry_pos ? POS_W'(geom.a_pos_y) - py_wide
                                  : POS_W'(geom.a_pos_y) + py_wide;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= geom.valid;
            valid_reg    <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_hit_reg <= geom.hit;
        prod_v_reg <= prod_v_next;
        prod_h_reg <= prod_h_next;
        pos_x_reg  <= sat_coord(SAT_W'(x_moved));
        pos_y_reg  <= sat_coord(SAT_W'(y_moved));
        apx_reg    <= geom.a_pos_x;
        apy_reg    <= geom.a_pos_y;
        avx_reg    <= geom.a_vel_x;
        avy_reg    <= geom.a_vel_y;
        bvx_reg    <= geom.b_vel_x;
        bvy_reg    <= geom.b_vel_y;
        for (int i = 0; i < NUM_VEL; i++)
        begin
            dvel_reg[i] <= damped[i];
        end
    end

    // Axis choice; a tie of the products resolves horizontally.
    always_comb
    begin
        out_next.hit         = s3_hit_reg;
        out_next.vertical    = s3_hit_reg && (prod_v_reg > prod_h_reg);
        out_next.new_a_pos_x = apx_reg;
        out_next.new_a_pos_y = apy_reg;
        out_next.new_a_vel_x = avx_reg;
        out_next.new_a_vel_y = avy_reg;
        out_next.new_b_vel_x = bvx_reg;
        out_next.new_b_vel_y = bvy_reg;
        if (s3_hit_reg)
        begin
            if (out_next.vertical)
            begin
                out_next.new_a_pos_y = pos_y_reg;
                out_next.new_a_vel_y = dvel_reg[VEL_BY];
                out_next.new_b_vel_y = dvel_reg[VEL_AY];
            end
            else
            begin
                out_next.new_a_pos_x = pos_x_reg;
                out_next.new_a_vel_x = dvel_reg[VEL_BX];
                out_next.new_b_vel_x = dvel_reg[VEL_AX];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = out_reg;
    assign busy      = s3_valid_reg || valid_reg;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the box collision response core.
`timescale 1ns / 1ps

module tb_top
    import cbr_pkg::*;
();

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    cbr_in_t  item;
    logic     done;
    cbr_out_t result;
    logic     cfg_valid;
    logic     cfg_ready;
    damp_t    cfg_data;

    // Responses predicted for accepted box pairs, oldest first.
    cbr_out_t predicted_responses[$];
    // Damping factor as the block should currently hold it.
    damp_t    damp_model;

    int mismatch_count;
    int pairs_checked;
    int hits_seen;
    int vertical_seen;
    int damping_writes;

    box_collision_response_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $display("Timed out with %0d results outstanding.", predicted_responses.size());
        $finish;
    end

    // Clamp a wide value to the signed coordinate range.
    function automatic coord_t clamp_coord(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return coord_t'(hi);
        end
        if (v < lo)
        begin
            return coord_t'(lo);
        end
        return coord_t'(v);
    endfunction

    // Velocity after a bounce: round to nearest with ties upward, then saturate.
    function automatic coord_t scale_speed(input longint v, input damp_t d);
        longint t;
        t = v * longint'(d) + (longint'(1) << (DAMP_FRAC - 1));
        return clamp_coord(t >>> DAMP_FRAC);
    endfunction

    // Predict the response for one box pair under damping factor d.
    function automatic cbr_out_t predict_response(input cbr_in_t p, input damp_t d);
        longint apx, apy, avx, avy, ah;
        longint bpx, bpy, bvx, bvy, bh;
        longint a_l, a_r, a_t, a_b, b_l, b_r, b_t, b_b;
        longint rx, ry, px, py, abs_rx, abs_ry;
        cbr_out_t r;
        apx = $signed(p.a_pos_x);
        apy = $signed(p.a_pos_y);
        avx = $signed(p.a_vel_x);
        avy = $signed(p.a_vel_y);
        ah  = p.a_half_size;
        bpx = $signed(p.b_pos_x);
        bpy = $signed(p.b_pos_y);
        bvx = $signed(p.b_vel_x);
        bvy = $signed(p.b_vel_y);
        bh  = p.b_half_size;

        // Without a hit everything passes through.
        r.hit         = 1'b0;
        r.vertical    = 1'b0;
        r.new_a_pos_x = p.a_pos_x;
        r.new_a_pos_y = p.a_pos_y;
        r.new_a_vel_x = p.a_vel_x;
        r.new_a_vel_y = p.a_vel_y;
        r.new_b_vel_x = p.b_vel_x;
        r.new_b_vel_y = p.b_vel_y;

        a_l = apx - ah;
        a_r = apx + ah;
        a_t = apy - ah;
        a_b = apy + ah;
        b_l = bpx - bh;
        b_r = bpx + bh;
        b_t = bpy - bh;
        b_b = bpy + bh;

        // Strict overlap on both axes; touching edges do not count.
        if (a_r > b_l && a_l < b_r && a_b > b_t && a_t < b_b)
        begin
            rx = avx - bvx;
            ry = avy - bvy;
            px = (rx > 0) ? (a_r - b_l) : (b_r - a_l);
            py = (ry > 0) ? (a_b - b_t) : (b_b - a_t);
            abs_rx = (rx < 0) ? -rx : rx;
            abs_ry = (ry < 0) ? -ry : ry;
            r.hit = 1'b1;
            // Equal cross products fall to the horizontal case.
            if (abs_ry * px > abs_rx * py)
            begin
                r.vertical    = 1'b1;
                r.new_a_pos_y = clamp_coord((ry > 0) ? apy - py : apy + py);
                r.new_a_vel_y = scale_speed(bvy, d);
                r.new_b_vel_y = scale_speed(avy, d);
            end
            else
            begin
                r.new_a_pos_x = clamp_coord((rx > 0) ? apx - px : apx + px);
                r.new_a_vel_x = scale_speed(bvx, d);
                r.new_b_vel_x = scale_speed(avx, d);
            end
        end
        return r;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input coord_t got, input coord_t want);
        if (got !== want)
        begin
            report_mismatch($sformatf("pair %0d %s: got %0d, expected %0d",
                                      pairs_checked, name, got, want));
        end
    endtask

    // Result checking and prediction, both sampled at the rising edge.
    always @(posedge clk)
    begin : response_check
        cbr_out_t want;
        if (rst_n && done)
        begin
            if (predicted_responses.size() == 0)
            begin
                report_mismatch("result beat with no box pair outstanding");
            end
            else
            begin
                want = predicted_responses.pop_front();
                check_field("hit",         coord_t'(result.hit),      coord_t'(want.hit));
                check_field("vertical",    coord_t'(result.vertical), coord_t'(want.vertical));
                check_field("new_a_pos_x", result.new_a_pos_x, want.new_a_pos_x);
                check_field("new_a_pos_y", result.new_a_pos_y, want.new_a_pos_y);
                check_field("new_a_vel_x", result.new_a_vel_x, want.new_a_vel_x);
                check_field("new_a_vel_y", result.new_a_vel_y, want.new_a_vel_y);
                check_field("new_b_vel_x", result.new_b_vel_x, want.new_b_vel_x);
                check_field("new_b_vel_y", result.new_b_vel_y, want.new_b_vel_y);
                pairs_checked++;
                hits_seen     += want.hit;
                vertical_seen += want.vertical;
            end
        end
        if (rst_n && start && !busy)
        begin
            predicted_responses.push_back(predict_response(item, damp_model));
        end
    end

    // Present one box pair and hold it until the block takes the beat.
    task automatic send_pair(input cbr_in_t p);
        item  <= p;
        start <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic wait_until_drained();
        start <= 1'b0;
        while (predicted_responses.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write the damping register; only called with the pipeline empty.
    task automatic write_damping(input damp_t v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        damp_model = v;
        damping_writes++;
    endtask

    function automatic cbr_in_t make_pair(input int apx, input int apy, input int avx,
                                          input int avy, input int ah, input int bpx,
                                          input int bpy, input int bvx, input int bvy,
                                          input int bh);
        cbr_in_t p;
        p.a_pos_x     = coord_t'(apx);
        p.a_pos_y     = coord_t'(apy);
        p.a_vel_x     = coord_t'(avx);
        p.a_vel_y     = coord_t'(avy);
        p.a_half_size = half_t'(ah);
        p.b_pos_x     = coord_t'(bpx);
        p.b_pos_y     = coord_t'(bpy);
        p.b_vel_x     = coord_t'(bvx);
        p.b_vel_y     = coord_t'(bvy);
        p.b_half_size = half_t'(bh);
        return p;
    endfunction

    // Mostly small boxes, now and then up to the full half-size range.
    function automatic longint pick_half();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom_range(0, (1 << HALF_WIDTH) - 1);
        end
        return $urandom_range(0, 1023);
    endfunction

    // Centre offset that overlaps, with the odd exactly touching case.
    function automatic longint pick_offset(input longint span);
        if (span == 0)
        begin
            return 0;
        end
        case ($urandom_range(0, 15))
            0: return span;
            1: return -span;
            default: return longint'($urandom_range(0, 2 * span - 2)) - (span - 1);
        endcase
    endfunction

    function automatic coord_t pick_speed();
        case ($urandom_range(0, 4))
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 512)) - 256);
            2: return '0;
            3: return ($urandom_range(0, 1) != 0) ? coord_t'(32767) : coord_t'(-32768);
            default: return coord_t'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    // Fully random pair; most of these miss.
    function automatic cbr_in_t random_pair();
        cbr_in_t p;
        p.a_pos_x     = coord_t'($urandom);
        p.a_pos_y     = coord_t'($urandom);
        p.a_vel_x     = coord_t'($urandom);
        p.a_vel_y     = coord_t'($urandom);
        p.a_half_size = half_t'($urandom);
        p.b_pos_x     = coord_t'($urandom);
        p.b_pos_y     = coord_t'($urandom);
        p.b_vel_x     = coord_t'($urandom);
        p.b_vel_y     = coord_t'($urandom);
        p.b_half_size = half_t'($urandom);
        return p;
    endfunction

    // Pair built to overlap, so that the resolution paths see most of the traffic.
    function automatic cbr_in_t random_overlapping_pair();
        cbr_in_t p;
        longint  ah;
        longint  bh;
        longint  span;
        ah = pick_half();
        bh = pick_half();
        span = ah + bh;
        p.a_half_size = half_t'(ah);
        p.b_half_size = half_t'(bh);
        p.a_pos_x = coord_t'($urandom);
        p.a_pos_y = coord_t'($urandom);
        p.b_pos_x = clamp_coord(longint'($signed(p.a_pos_x)) + pick_offset(span));
        p.b_pos_y = clamp_coord(longint'($signed(p.a_pos_y)) + pick_offset(span));
        p.a_vel_x = pick_speed();
        p.a_vel_y = pick_speed();
        p.b_vel_x = ($urandom_range(0, 7) == 0) ? p.a_vel_x : pick_speed();
        p.b_vel_y = ($urandom_range(0, 7) == 0) ? p.a_vel_y : pick_speed();
        return p;
    endfunction

    // Directed pairs under the reset damping factor.
    task automatic test_default_damping();
        // Clear miss, and boxes touching on x and on y.
        send_pair(make_pair(0, 0, 10, 10, 16, 1000, 0, -10, 0, 16));
        send_pair(make_pair(0, 0, 10, 0, 16, 32, 0, -10, 0, 16));
        send_pair(make_pair(0, 0, 0, 10, 16, 0, 32, 0, -10, 16));
        // Zero-size boxes on the same centre never overlap.
        send_pair(make_pair(5, 5, 7, 7, 0, 5, 5, -7, -7, 0));
        // Horizontal resolution, A moving right, then left.
        send_pair(make_pair(0, 0, 64, 0, 16, 20, 0, -32, 0, 16));
        send_pair(make_pair(20, 0, -64, 0, 16, 0, 0, 32, 0, 16));
        // Vertical resolution, A moving down, then up.
        send_pair(make_pair(0, 0, 0, 64, 16, 0, 20, 0, -32, 16));
        send_pair(make_pair(0, 20, 0, -64, 16, 0, 0, 0, 32, 16));
        // Equal cross products: no relative motion, then equal relative speeds.
        send_pair(make_pair(3, -3, 100, -100, 16, 0, 0, 100, -100, 16));
        send_pair(make_pair(0, 0, -5, -5, 16, 0, 0, 0, 0, 16));
        // Position pushed past the top and the bottom of the range.
        send_pair(make_pair(32767, 32767, -32768, -32768, 16383,
                            32767, 32767, 32767, 32767, 16383));
        send_pair(make_pair(-32768, -32768, 32767, 32767, 16383,
                            -32768, -32768, -32768, -32768, 16383));
        send_pair(make_pair(-32768, -32768, 0, 32767, 16383,
                            -32768, -32768, 0, -32768, 16383));
        // One box of full size around a point-sized one.
        send_pair(make_pair(0, 0, 21845, -21846, 16383, 100, -100, -21846, 21845, 0));
        wait_until_drained();
    endtask

    // Damping at zero, at unity and at the register's largest value.
    task automatic test_damping_extremes();
        damp_t settings[3];
        settings = '{damp_t'(0), damp_t'(256), damp_t'((1 << DAMP_WIDTH) - 1)};
        foreach (settings[i])
        begin
            write_damping(settings[i]);
            send_pair(make_pair(0, 0, 64, 0, 16, 20, 0, -32, 0, 16));
            send_pair(make_pair(0, 20, 0, -64, 16, 0, 0, 0, 32, 16));
            send_pair(make_pair(32767, 32767, -32768, -32768, 16383,
                                32767, 32767, 32767, 32767, 16383));
            wait_until_drained();
        end
    endtask

    // Random pairs; each chunk of 40 is sent gappy or dense at random (always dense without gaps).
    task automatic run_random_pairs(input int count, input bit with_gaps);
        bit      gappy;
        cbr_in_t p;
        gappy = 1'b0;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                gappy = with_gaps && ($urandom_range(0, 2) != 0);
            end
            if (gappy && $urandom_range(0, 3) == 0)
            begin
                pause_sender($urandom_range(1, 9));
            end
            p = ($urandom_range(0, 9) < 7) ? random_overlapping_pair() : random_pair();
            send_pair(p);
        end
    endtask

    // Random traffic with sender gaps, under a random and a half-scale damping.
    task automatic test_random_with_gaps();
        write_damping(damp_t'($urandom_range(0, (1 << DAMP_WIDTH) - 1)));
        run_random_pairs(600, 1'b1);
        wait_until_drained();
        write_damping(damp_t'(128));
        run_random_pairs(600, 1'b1);
        wait_until_drained();
    endtask

    // Closing stretch: one pair every clock with no gaps at all.
    task automatic test_back_to_back();
        write_damping(damp_t'($urandom_range(1, 256)));
        run_random_pairs(400, 1'b0);
        wait_until_drained();
    endtask

    // Reset, then the tests in turn, then the verdict.
    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        damp_model     = DAMP_RESET;
        mismatch_count = 0;
        pairs_checked  = 0;
        hits_seen      = 0;
        vertical_seen  = 0;
        damping_writes = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_damping();
        test_damping_extremes();
        test_random_with_gaps();
        test_back_to_back();

        // Tail: let anything still in the pipeline come out.
        for (int i = 0; i < 1000 && predicted_responses.size() != 0; i++)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (predicted_responses.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived",
                                      predicted_responses.size()));
        end

        $display("Checked %0d box pairs: %0d collisions, %0d of them resolved vertically.",
                 pairs_checked, hits_seen, vertical_seen);
        $display("Damping written %0d times (0, 128, 256, 511 and random); %0d mismatches.",
                 damping_writes, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
